@@ sv/scpf_pkg.sv @@
package scpf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CSQ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CREC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLD_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLD_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLD_Z  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd7;

    localparam logic REQ_PAIR = 1'b0;
    localparam logic REQ_SELF = 1'b1;

    localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [62:0]        MAG_CAP = 63'(1) << 62;
    localparam logic [31:0]        GAIN_RST = 32'(1) << FRAC_BITS;

    // pipeline map
    localparam int ST_RSQ   = 1;
    localparam int ST_SQ0   = 2;
    localparam int SQ_STEPS = 32;
    localparam int ST_SCL   = ST_SQ0 + SQ_STEPS;
    localparam int ST_PW0   = ST_SCL + 1;
    localparam int PW_STEPS = 16;
    localparam int ST_SH    = ST_PW0 + PW_STEPS;
    localparam int ST_LAM   = ST_SH + 1;
    localparam int ST_D1I   = ST_LAM + 1;
    localparam int QBITS    = 63;
    localparam int ST_D10   = ST_D1I + 1;
    localparam int ST_D2I   = ST_D10 + QBITS;
    localparam int ST_D20   = ST_D2I + 1;
    localparam int ST_MF    = ST_D20 + QBITS;
    localparam int ST_FS    = ST_MF + 1;
    localparam int ST_MA    = ST_FS + 1;
    localparam int ST_OUT   = ST_MA + 1;
    localparam int NSTG     = ST_OUT + 1;

    typedef struct packed {
        logic                  self_req;
        logic                  ghost;
        logic                  id_lower;
        logic                  in_rng;
        logic [2:0]            d_neg;
        logic [2:0][31:0]      d_mag;
        logic                  qo_neg;
        logic                  qp_neg;
        logic [15:0]           qo_mag;
        logic [30:0]           qq;
        logic [31:0]           im_own;
        logic [31:0]           im_par;
        logic [15:0]           lam;
        logic [2:0][62:0]      sq;
        logic [63:0]           r2;
        logic [63:0]           sv;
        logic [63:0]           root;
        logic [31:0]           r;
        logic [FRAC_BITS:0]    s;
        logic [FRAC_BITS:0]    p;
        logic [54:0]           n;
        logic [63:0]           rem;
        logic [62:0]           quo;
        logic                  ovf;
        logic [62:0]           t;
        logic [2:0][63:0]      fp_lo;
        logic [2:0][62:0]      fp_hi;
        logic [3:0][63:0]      vp;
        logic [2:0][39:0]      fq;
        logic [2:0][62:0]      f;
        logic [62:0]           vir;
        logic [2:0][55:0]      fs;
        logic [5:0][63:0]      ap_lo;
        logic [5:0][62:0]      ap_hi;
        logic [2:0][47:0]      acc_o;
        logic [2:0][47:0]      acc_p;
        logic [47:0]           vir_o;
    } t_item;

endpackage

@@ sv/scpf_in_if.sv @@
interface scpf_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic signed [15:0] charge_own;
    logic signed [15:0] charge_partner;
    logic [31:0]        inv_mass_own;
    logic [31:0]        inv_mass_partner;
    logic [15:0]        pair_scale;
    logic               own_id_lower;
    logic               partner_ghost;

    modport source(output valid, req_type, offset_x, offset_y, offset_z, charge_own,
                   charge_partner, inv_mass_own, inv_mass_partner, pair_scale,
                   own_id_lower, partner_ghost, input ready);
    modport sink(input valid, req_type, offset_x, offset_y, offset_z, charge_own,
                 charge_partner, inv_mass_own, inv_mass_partner, pair_scale,
                 own_id_lower, partner_ghost, output ready);
endinterface

@@ sv/scpf_out_if.sv @@
interface scpf_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] acc_own_x;
    logic signed [47:0] acc_own_y;
    logic signed [47:0] acc_own_z;
    logic signed [47:0] acc_partner_x;
    logic signed [47:0] acc_partner_y;
    logic signed [47:0] acc_partner_z;
    logic signed [47:0] virial_term;
    logic               in_range;

    modport source(output valid, acc_own_x, acc_own_y, acc_own_z, acc_partner_x,
                   acc_partner_y, acc_partner_z, virial_term, in_range, input ready);
    modport sink(input valid, acc_own_x, acc_own_y, acc_own_z, acc_partner_x,
                 acc_partner_y, acc_partner_z, virial_term, in_range, output ready);
endinterface

@@ sv/shifted_coulomb_pair_force.sv @@
// Shifted Coulomb pair force unit. Takes one item (a neighbor pair or an
// external-field self term) per clock while the output is not stalled, and returns
// exactly one result per item, in order. The pipeline depth is set by the 32-step
// square root and the two
// 63-step restoring dividers (r^2 and r), each retiring one root or quotient bit per
// pipeline stage. The whole pipe advances when the output register is empty or taken,
// so a stall on the output freezes every stage and drops nothing. Configuration is
// written through a plain write port and must only change while the pipe is empty.
// All arithmetic is Q16.16 with magnitudes held to 2^62; outputs saturate to 48 bits.
module shifted_coulomb_pair_force (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    scpf_in_if.sink                          i_req,
    scpf_out_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [scpf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scpf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import scpf_pkg::*;

    logic [31:0]       r_gain;
    logic [31:0]       r_csq;
    logic [31:0]       r_crec;
    logic [3:0]        r_beta;
    logic [2:0][31:0]  r_fld;
    logic              r_scale;

    logic [NSTG-1:0]   r_vld;
    t_item             r_pipe [NSTG];
    t_item             n_pipe [NSTG];
    t_item             s0_item;
    logic              adv;

    // ---------------------------------------------------------------- helpers
    function automatic logic [62:0] f_cap(input logic [127:0] v);
        return (v > 128'(MAG_CAP)) ? MAG_CAP : v[62:0];
    endfunction

    function automatic logic [47:0] f_out48(input logic neg, input logic [62:0] mag);
        logic [62:0] m;
        if (neg) begin
            m = (mag > (63'(1) << 47)) ? (63'(1) << 47) : mag;
            return (~m[47:0]) + 48'd1;
        end
        m = (mag > ((63'(1) << 47) - 63'd1)) ? ((63'(1) << 47) - 63'd1) : mag;
        return m[47:0];
    endfunction

    function automatic t_item f_rsq(input t_item xi, input logic [31:0] gain,
                                    input logic [31:0] csq);
        t_item       x;
        logic [63:0] prod;
        x = xi;
        x.r2   = 64'(x.sq[0]) + 64'(x.sq[1]) + 64'(x.sq[2]);
        x.sv   = x.r2;
        x.root = '0;
        prod   = 64'(gain) * 64'(x.qq);
        x.n    = 55'(prod >> 16);
        x.in_rng = (x.self_req == REQ_SELF) ||
                   ((x.r2 != 64'd0) && (x.r2 < (64'(csq) << FRAC_BITS)));
        return x;
    endfunction

    function automatic t_item f_sqrt(input t_item xi, input int k);
        t_item       x;
        logic [64:0] trial;
        logic [63:0] b;
        x     = xi;
        b     = 64'd1 << (2 * k);
        trial = 65'(x.root) + 65'(b);
        if ({1'b0, x.sv} >= trial) begin
            x.sv   = x.sv - trial[63:0];
            x.root = (x.root >> 1) + b;
        end else begin
            x.root = x.root >> 1;
        end
        return x;
    endfunction

    function automatic t_item f_scl(input t_item xi, input logic [31:0] crec);
        t_item       x;
        logic [63:0] prod;
        logic [63:0] sc;
        x      = xi;
        x.r    = x.root[31:0];
        prod   = 64'(x.r) * 64'(crec);
        sc     = prod >> FRAC_BITS;
        x.s    = (sc > 64'(ONE_FX)) ? ONE_FX : sc[FRAC_BITS:0];
        x.p    = ONE_FX;
        return x;
    endfunction

    function automatic t_item f_pow(input t_item xi, input int j, input logic [3:0] beta);
        t_item                     x;
        logic [2*FRAC_BITS+1:0]    prod;
        x    = xi;
        prod = (2*FRAC_BITS+2)'(x.p) * (2*FRAC_BITS+2)'(x.s);
        if (j <= int'(beta)) begin
            x.p = (FRAC_BITS+1)'(prod >> FRAC_BITS);
        end
        return x;
    endfunction

    function automatic t_item f_shift(input t_item xi);
        t_item              x;
        logic [FRAC_BITS:0] shv;
        logic [71+FRAC_BITS:0] prod;
        x    = xi;
        shv  = ONE_FX - x.p;
        prod = (72+FRAC_BITS)'(x.n) * (72+FRAC_BITS)'(shv);
        x.n  = 55'(prod >> FRAC_BITS);
        return x;
    endfunction

    function automatic t_item f_lam(input t_item xi, input logic scale);
        t_item       x;
        logic [70:0] prod;
        x    = xi;
        prod = 71'(x.n) * 71'(x.lam);
        if (scale) begin
            x.n = 55'(prod >> 8);
        end
        return x;
    endfunction

    // first step of a restoring divide: top dividend bits, overflow check
    function automatic t_item f_dinit(input t_item xi, input logic [62:0] src,
                                      input int sh, input logic [63:0] den);
        t_item x;
        x     = xi;
        x.rem = 64'(src >> (63 - sh));
        x.ovf = (x.rem >= den);
        x.quo = '0;
        return x;
    endfunction

    function automatic t_item f_dstep(input t_item xi, input logic [62:0] src,
                                      input int sh, input logic [63:0] den, input int qb);
        t_item       x;
        logic        nb;
        logic [64:0] part;
        logic [64:0] diff;
        x    = xi;
        nb   = (qb >= sh) ? src[qb - sh] : 1'b0;
        part = {x.rem, nb};
        diff = part - {1'b0, den};
        if (part >= {1'b0, den}) begin
            x.rem     = diff[63:0];
            x.quo[qb] = 1'b1;
        end else begin
            x.rem = part[63:0];
        end
        return x;
    endfunction

    function automatic logic [62:0] f_quot(input t_item x);
        return (x.ovf || (x.quo > MAG_CAP)) ? MAG_CAP : x.quo;
    endfunction

    function automatic t_item f_mf(input t_item xi, input logic [2:0][31:0] fld);
        t_item       x;
        logic [62:0] coef;
        logic [31:0] fm;
        logic [47:0] fprod;
        x    = xi;
        coef = f_quot(xi);
        for (int i = 0; i < 3; i++) begin
            x.fp_lo[i] = 64'(coef[31:0]) * 64'(x.d_mag[i]);
            x.fp_hi[i] = 63'(coef[62:32]) * 63'(x.d_mag[i]);
            fm         = fld[i][31] ? (~fld[i] + 32'd1) : fld[i];
            fprod      = 48'(fm) * 48'(x.qo_mag);
            x.fq[i]    = 40'(fprod >> 8);
        end
        x.vp[0] = 64'(coef[62:32]) * 64'(x.r2[63:32]);
        x.vp[1] = 64'(coef[62:32]) * 64'(x.r2[31:0]);
        x.vp[2] = 64'(coef[31:0]) * 64'(x.r2[63:32]);
        x.vp[3] = 64'(coef[31:0]) * 64'(x.r2[31:0]);
        return x;
    endfunction

    function automatic t_item f_fs(input t_item xi);
        t_item        x;
        logic [127:0] sum;
        x = xi;
        for (int i = 0; i < 3; i++) begin
            sum     = (128'(x.fp_hi[i]) << 32) + 128'(x.fp_lo[i]);
            x.f[i]  = f_cap(sum >> FRAC_BITS);
            x.fs[i] = 56'(x.fq[i]) * 56'(x.lam);
        end
        sum   = (128'(x.vp[0]) << 64) + (128'(x.vp[1]) << 32) + (128'(x.vp[2]) << 32)
              + 128'(x.vp[3]);
        x.vir = f_cap(sum >> (2 * FRAC_BITS));
        return x;
    endfunction

    function automatic t_item f_ma(input t_item xi, input logic scale);
        t_item       x;
        logic [62:0] fsel;
        x = xi;
        for (int i = 0; i < 3; i++) begin
            if (x.self_req == REQ_SELF) begin
                fsel = scale ? 63'(x.fs[i] >> 8) : 63'(x.fq[i]);
            end else begin
                fsel = x.f[i];
            end
            x.ap_lo[i]   = 64'(fsel[31:0]) * 64'(x.im_own);
            x.ap_hi[i]   = 63'(fsel[62:32]) * 63'(x.im_own);
            x.ap_lo[3+i] = 64'(fsel[31:0]) * 64'(x.im_par);
            x.ap_hi[3+i] = 63'(fsel[62:32]) * 63'(x.im_par);
        end
        return x;
    endfunction

    function automatic t_item f_fin(input t_item xi, input logic [2:0][31:0] fld);
        t_item             x;
        logic [5:0][62:0]  am;
        logic              cneg;
        logic              fneg;
        x = xi;
        for (int i = 0; i < 6; i++) begin
            am[i] = f_cap(((128'(x.ap_hi[i]) << 32) + 128'(x.ap_lo[i])) >> FRAC_BITS);
        end
        // like charges repel: coefficient negative
        cneg    = (x.qo_neg == x.qp_neg);
        x.acc_o = '0;
        x.acc_p = '0;
        x.vir_o = '0;
        for (int i = 0; i < 3; i++) begin
            if (x.self_req == REQ_SELF) begin
                x.acc_o[i] = f_out48(fld[i][31] ^ x.qo_neg, am[i]);
            end else if (x.in_rng) begin
                fneg       = cneg ^ x.d_neg[i];
                x.acc_o[i] = f_out48(fneg, am[i]);
                if (!x.ghost) begin
                    x.acc_p[i] = f_out48(!fneg, am[3+i]);
                end
            end
        end
        if (x.self_req != REQ_SELF && x.in_rng && x.id_lower) begin
            x.vir_o = f_out48(!cneg, x.vir);
        end
        return x;
    endfunction

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_csq   <= '0;
            r_crec  <= '0;
            r_beta  <= 4'd1;
            r_fld   <= '0;
            r_scale <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN:  r_gain   <= i_cfg_data;
                CFG_CSQ:   r_csq    <= i_cfg_data;
                CFG_CREC:  r_crec   <= i_cfg_data;
                CFG_BETA:  r_beta   <= i_cfg_data[3:0];
                CFG_FLD_X: r_fld[0] <= i_cfg_data;
                CFG_FLD_Y: r_fld[1] <= i_cfg_data;
                CFG_FLD_Z: r_fld[2] <= i_cfg_data;
                CFG_SCALE: r_scale  <= i_cfg_data[0];
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 0
    always_comb begin
        logic [2:0][31:0] u;
        logic [15:0]      qo;
        logic [15:0]      qp;
        logic [15:0]      qpm;
        s0_item          = '0;
        u[0]             = i_req.offset_x;
        u[1]             = i_req.offset_y;
        u[2]             = i_req.offset_z;
        qo               = i_req.charge_own;
        qp               = i_req.charge_partner;
        s0_item.self_req = i_req.req_type;
        s0_item.ghost    = i_req.partner_ghost;
        s0_item.id_lower = i_req.own_id_lower;
        for (int i = 0; i < 3; i++) begin
            s0_item.d_neg[i] = u[i][31];
            s0_item.d_mag[i] = u[i][31] ? (~u[i] + 32'd1) : u[i];
            s0_item.sq[i]    = 63'(64'(s0_item.d_mag[i]) * 64'(s0_item.d_mag[i]));
        end
        s0_item.qo_neg = qo[15];
        s0_item.qp_neg = qp[15];
        s0_item.qo_mag = qo[15] ? (~qo + 16'd1) : qo;
        qpm            = qp[15] ? (~qp + 16'd1) : qp;
        s0_item.qq     = 31'(32'(s0_item.qo_mag) * 32'(qpm));
        s0_item.im_own = i_req.inv_mass_own;
        s0_item.im_par = i_req.inv_mass_partner;
        s0_item.lam    = i_req.pair_scale;
    end

    assign n_pipe[0]      = s0_item;
    assign n_pipe[ST_RSQ] = f_rsq(r_pipe[ST_RSQ-1], r_gain, r_csq);

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        assign n_pipe[ST_SQ0+j] = f_sqrt(r_pipe[ST_SQ0+j-1], SQ_STEPS - 1 - j);
    end

    assign n_pipe[ST_SCL] = f_scl(r_pipe[ST_SCL-1], r_crec);

    for (genvar j = 0; j < PW_STEPS; j++) begin : g_pow
        assign n_pipe[ST_PW0+j] = f_pow(r_pipe[ST_PW0+j-1], j, r_beta);
    end

    assign n_pipe[ST_SH]  = f_shift(r_pipe[ST_SH-1]);
    assign n_pipe[ST_LAM] = f_lam(r_pipe[ST_LAM-1], r_scale);

    // t = n * 2^(2F) / r^2
    assign n_pipe[ST_D1I] = f_dinit(r_pipe[ST_D1I-1], 63'(r_pipe[ST_D1I-1].n),
                                    2 * FRAC_BITS, r_pipe[ST_D1I-1].r2);
    for (genvar j = 0; j < QBITS; j++) begin : g_div1
        assign n_pipe[ST_D10+j] = f_dstep(r_pipe[ST_D10+j-1], 63'(r_pipe[ST_D10+j-1].n),
                                          2 * FRAC_BITS, r_pipe[ST_D10+j-1].r2,
                                          QBITS - 1 - j);
    end

    // coef = t * 2^F / r
    always_comb begin
        t_item x;
        x   = r_pipe[ST_D2I-1];
        x.t = f_quot(r_pipe[ST_D2I-1]);
        n_pipe[ST_D2I] = f_dinit(x, x.t, FRAC_BITS, 64'(x.r));
    end
    for (genvar j = 0; j < QBITS; j++) begin : g_div2
        assign n_pipe[ST_D20+j] = f_dstep(r_pipe[ST_D20+j-1], r_pipe[ST_D20+j-1].t,
                                          FRAC_BITS, 64'(r_pipe[ST_D20+j-1].r),
                                          QBITS - 1 - j);
    end

    assign n_pipe[ST_MF]  = f_mf(r_pipe[ST_MF-1], r_fld);
    assign n_pipe[ST_FS]  = f_fs(r_pipe[ST_FS-1]);
    assign n_pipe[ST_MA]  = f_ma(r_pipe[ST_MA-1], r_scale);
    assign n_pipe[ST_OUT] = f_fin(r_pipe[ST_OUT-1], r_fld);

    // ---------------------------------------------------------------- pipe
    assign adv         = !r_vld[ST_OUT] || o_res.ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NSTG; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign o_res.valid         = r_vld[ST_OUT];
    assign o_res.acc_own_x     = r_pipe[ST_OUT].acc_o[0];
    assign o_res.acc_own_y     = r_pipe[ST_OUT].acc_o[1];
    assign o_res.acc_own_z     = r_pipe[ST_OUT].acc_o[2];
    assign o_res.acc_partner_x = r_pipe[ST_OUT].acc_p[0];
    assign o_res.acc_partner_y = r_pipe[ST_OUT].acc_p[1];
    assign o_res.acc_partner_z = r_pipe[ST_OUT].acc_p[2];
    assign o_res.virial_term   = r_pipe[ST_OUT].vir_o;
    assign o_res.in_range      = r_pipe[ST_OUT].in_rng;

    // ---------------------------------------------------------------- checks
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_vld[0])
        else $error("accepted item missing from first stage");

    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.in_range |->
            o_res.acc_own_x == 48'd0 && o_res.acc_own_y == 48'd0 &&
            o_res.acc_own_z == 48'd0 && o_res.acc_partner_x == 48'd0 &&
            o_res.acc_partner_y == 48'd0 && o_res.acc_partner_z == 48'd0 &&
            o_res.virial_term == 48'd0)
        else $error("out-of-range item has nonzero result");

    a_partner_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.acc_partner_x != 48'd0 || o_res.acc_partner_y != 48'd0 ||
            o_res.acc_partner_z != 48'd0 || o_res.virial_term != 48'd0) |->
            o_res.in_range)
        else $error("reaction or virial outside cutoff");

endmodule
